// ===== rtl/spq_pkg.sv =====
// Package for the stable priority queue: command group and status codes.
// No dependencies; every module in rtl/ imports it.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Command broadcast from the top level to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the new entry behind all entries of lower or equal priority
        logic rem;   // shift every entry one place towards the head
    } spq_cmd_t;

    typedef logic [1:0] spq_status_t;

    localparam spq_status_t ST_INSERTED = 2'd0;
    localparam spq_status_t ST_REMOVED  = 2'd1;
    localparam spq_status_t ST_EMPTY    = 2'd2;
    localparam spq_status_t ST_FULL     = 2'd3;

endpackage : spq_pkg

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds a priority, a value tag and a valid bit.
// Depends on spq_pkg for the command group.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  spq_pkg::spq_cmd_t                cmd,
    input  wire signed [PRIORITY_WIDTH-1:0]  new_pri,
    input  wire        [VALUE_WIDTH-1:0]     new_val,
    // neighbour towards the head
    input  wire                              left_valid,
    input  wire                              left_keep,
    input  wire signed [PRIORITY_WIDTH-1:0]  left_pri,
    input  wire        [VALUE_WIDTH-1:0]     left_val,
    // neighbour towards the tail
    input  wire                              right_valid,
    input  wire signed [PRIORITY_WIDTH-1:0]  right_pri,
    input  wire        [VALUE_WIDTH-1:0]     right_val,
    // own state, seen by both neighbours
    output logic                             valid,
    output logic                             keep,
    output logic signed [PRIORITY_WIDTH-1:0] pri,
    output logic       [VALUE_WIDTH-1:0]     val
);
    import spq_pkg::*;

    logic                             valid_reg, valid_next;
    logic signed [PRIORITY_WIDTH-1:0] pri_reg, pri_next;
    logic        [VALUE_WIDTH-1:0]    val_reg, val_next;

    // Entry stays put on insert when it is served no later than the new one
    assign keep  = valid_reg && (pri_reg <= new_pri);
    assign valid = valid_reg;
    assign pri   = pri_reg;
    assign val   = val_reg;

    // Hold, take the new entry, shift from the left, or shift from the right
    always_comb begin
        valid_next = valid_reg;
        pri_next   = pri_reg;
        val_next   = val_reg;
        if (cmd.ins) begin
            valid_next = valid_reg | left_valid;
            if (!keep) begin
                if (left_keep) begin
                    pri_next = new_pri;
                    val_next = new_val;
                end else begin
                    pri_next = left_pri;
                    val_next = left_val;
                end
            end
        end else if (cmd.rem) begin
            valid_next = right_valid;
            pri_next   = right_pri;
            val_next   = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pri_reg <= pri_next;
        val_reg <= val_next;
    end

endmodule : spq_cell

`default_nettype wire

// ===== rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: stream handshake, count and result register.
// Depends on spq_pkg and spq_cell.
//
//  Channel  Direction  tdata (low bit up)                     tuser
//  s_       in         item_value, item_priority              action
//  m_       out        out_value, out_priority, entry_count   status
//
// All cells compare against the new priority in parallel and shift by one place, so
// the chain takes one insert or remove per cycle while s_tready is high.
// The result register sits between the sides; a new transaction is taken while
// the held result is being taken downstream. A stall on m_ holds the result and
// backs up s_tready. Reset clears the valid bits, the count and the result flag;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    localparam int CountWidth    = $clog2(QUEUE_DEPTH + 1),
    localparam int InWidth       = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
    localparam int OutWidth      = ((VALUE_WIDTH + PRIORITY_WIDTH + CountWidth + 7) / 8) * 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire [InWidth-1:0]   s_tdata,   // item_value, item_priority
    input  wire                 s_tuser,   // action
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [OutWidth-1:0] m_tdata,   // out_value, out_priority, entry_count
    output spq_pkg::spq_status_t m_tuser   // status
);
    import spq_pkg::*;

    localparam int PriLsb = VALUE_WIDTH;
    localparam int CntLsb = VALUE_WIDTH + PRIORITY_WIDTH;

    logic                             accept;
    logic                             action;
    logic signed [PRIORITY_WIDTH-1:0] in_pri;
    logic        [VALUE_WIDTH-1:0]    in_val;
    logic                             is_full, is_empty;
    spq_cmd_t                         cmd;

    logic [CountWidth-1:0]            count_reg, count_next;
    logic                             m_valid_reg;
    spq_status_t                      status_reg, status_next;
    logic        [VALUE_WIDTH-1:0]    oval_reg, oval_next;
    logic signed [PRIORITY_WIDTH-1:0] opri_reg, opri_next;
    logic [CountWidth-1:0]            ocnt_reg;

    logic                             cell_valid [QUEUE_DEPTH];
    logic                             cell_keep  [QUEUE_DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] cell_pri   [QUEUE_DEPTH];
    logic        [VALUE_WIDTH-1:0]    cell_val   [QUEUE_DEPTH];

    // Unpack the input transaction
    assign action   = s_tuser;
    assign in_val   = s_tdata[VALUE_WIDTH-1:0];
    assign in_pri   = s_tdata[PriLsb +: PRIORITY_WIDTH];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_full  = (count_reg == CountWidth'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    assign cmd.ins  = accept && !action && !is_full;
    assign cmd.rem  = accept &&  action && !is_empty;

    // Chain of cells, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                             lv, lk;
        logic signed [PRIORITY_WIDTH-1:0] lp, rp;
        logic        [VALUE_WIDTH-1:0]    lval, rval;
        logic                             rv;

        if (i == 0) begin : g_head
            assign lv   = 1'b1;
            assign lk   = 1'b1;
            assign lp   = in_pri;
            assign lval = in_val;
        end else begin : g_body
            assign lv   = cell_valid[i-1];
            assign lk   = cell_keep[i-1];
            assign lp   = cell_pri[i-1];
            assign lval = cell_val[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign rv   = 1'b0;
            assign rp   = '0;
            assign rval = '0;
        end else begin : g_inner
            assign rv   = cell_valid[i+1];
            assign rp   = cell_pri[i+1];
            assign rval = cell_val[i+1];
        end

        spq_cell #(
            .VALUE_WIDTH   (VALUE_WIDTH),
            .PRIORITY_WIDTH(PRIORITY_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .new_pri    (in_pri),
            .new_val    (in_val),
            .left_valid (lv),
            .left_keep  (lk),
            .left_pri   (lp),
            .left_val   (lval),
            .right_valid(rv),
            .right_pri  (rp),
            .right_val  (rval),
            .valid      (cell_valid[i]),
            .keep       (cell_keep[i]),
            .pri        (cell_pri[i]),
            .val        (cell_val[i])
        );
    end

    // Advance the count and build the result of this transaction
    always_comb begin
        count_next  = count_reg;
        oval_next   = '0;
        opri_next   = '0;
        status_next = ST_INSERTED;
        if (!action) begin
            if (is_full) begin
                status_next = ST_FULL;
            end else begin
                count_next  = count_reg + 1'b1;
            end
        end else begin
            if (is_empty) begin
                status_next = ST_EMPTY;
            end else begin
                status_next = ST_REMOVED;
                count_next  = count_reg - 1'b1;
                oval_next   = cell_val[0];
                opri_next   = cell_pri[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            oval_reg   <= oval_next;
            opri_reg   <= opri_next;
            ocnt_reg   <= count_next;
        end
    end

    // Pack the result transaction
    always_comb begin
        m_tdata                            = '0;
        m_tdata[VALUE_WIDTH-1:0]           = oval_reg;
        m_tdata[PriLsb +: PRIORITY_WIDTH]  = opri_reg;
        m_tdata[CntLsb +: CountWidth]      = ocnt_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;

endmodule : stable_priority_queue

`default_nettype wire
